// File: design/pbfhs_pkg.sv
// Package for the point bump first-hit search unit: payload structs, register
// map, field widths and the default table depth.
// No dependencies; imported by the top level, its checker and the bench.
package pbfhs_pkg;

  localparam int COORD_BITS          = 24;
  localparam int DEFAULT_MAX_ENTRIES = 64;
  localparam int THRESH_W            = 50;
  localparam int COUNT_W             = 7;
  localparam int INDEX_W             = 6;

  // APB-style configuration port: 64-bit data, registers at 8-byte spacing.
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 64;
  localparam int REG_SEL_BIT = 3;

  localparam logic REG_MAX_DIST_SQ = 1'b0;
  localparam logic REG_ATOM_COUNT  = 1'b1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                         mode;
    logic [INDEX_W-1:0]           entry_index;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] hit_index;
  } out_item_t;

endpackage

// File: design/point_bump_first_hit_search_unit.sv
// Point bump first-hit search: a load beat writes one table slot and yields its
// result beat via the done state. A query scans slots in order through one
// shared subtract/square/accumulate unit, one axis a cycle. One item is in work
// at a time; the input stalls meanwhile.
// Synchronous active-low reset clears control state and configuration registers;
// the table and the datapath and result registers hold no reset.
module point_bump_first_hit_search_unit
  import pbfhs_pkg::*;
#(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW0   = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (CW0 > COUNT_W) ? CW0 : COUNT_W;
  localparam int MAG_W = COORD_BITS + 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int CMP_W = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
  localparam int ENT_W = 3 * COORD_BITS;
  localparam logic [CW-1:0] N_MAX = CW'(MAX_ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // Configuration registers
  logic [THRESH_W-1:0] max_dist_sq_r;
  logic [COUNT_W-1:0]  atom_count_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_sq_r <= '0;
      atom_count_r  <= '0;
    end else if (cfg_wr) begin
      case (paddr[REG_SEL_BIT])
        REG_MAX_DIST_SQ: max_dist_sq_r <= pwdata[THRESH_W-1:0];
        REG_ATOM_COUNT:  atom_count_r  <= pwdata[COUNT_W-1:0];
        default:         max_dist_sq_r <= max_dist_sq_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_MAX_DIST_SQ: prdata = APB_DATA_W'(max_dist_sq_r);
      REG_ATOM_COUNT:  prdata = APB_DATA_W'(atom_count_r);
      default:         prdata = '0;
    endcase
  end

  // Control and payload registers
  logic [1:0]            state_r, state_nxt;
  logic [CW-1:0]         j_r, j_nxt;
  logic [1:0]            ax_r, ax_nxt;
  logic [CW-1:0]         k_r, k_nxt;
  logic                  res_hit_r, res_hit_nxt;
  logic [INDEX_W-1:0]    res_idx_r, res_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;
  logic [COORD_BITS-1:0] q_x_r, q_y_r, q_z_r;

  // Shared arithmetic pipeline
  logic [ENT_W-1:0] rd_r;
  logic [MAG_W-1:0] mag_r;
  logic             mag_v_r, mag_first_r, mag_last_r;
  logic [SQ_W-1:0]  sq_r;
  logic             sq_v_r, sq_first_r, sq_last_r;
  logic [SUM_W-1:0] acc_r;

  logic              in_acc, wr_en, issuing, decide, bump;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CW-1:0]     n_c, j_inc, k_inc;
  logic [COORD_BITS-1:0] sel_q, sel_s;
  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]  mag_c;
  logic [SUM_W-1:0]  sum_c;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign n_c     = (CW'(atom_count_r) > N_MAX) ? N_MAX : CW'(atom_count_r);
  assign issuing = (state_r == ST_SCAN) && (j_r < n_c);
  assign j_inc   = j_r + 1'b1;
  assign k_inc   = k_r + 1'b1;

  assign wr_en   = in_acc && (in_data.mode == MODE_LOAD) &&
                   (32'(in_data.entry_index) < 32'(MAX_ENTRIES));
  assign wr_addr = AW'(in_data.entry_index);

  // Move to the next slot's address during the last axis, so the registered
  // read is ready when that slot's first axis is issued.
  always_comb begin
    if (state_r != ST_SCAN) begin
      rd_addr = '0;
    end else if (issuing && ax_r == AX_Z) begin
      rd_addr = j_inc[AW-1:0];
    end else begin
      rd_addr = j_r[AW-1:0];
    end
  end

  logic [ENT_W-1:0] mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    case (ax_r)
      AX_X: begin
        sel_q = q_x_r;
        sel_s = rd_r[ENT_W-1 -: COORD_BITS];
      end
      AX_Y: begin
        sel_q = q_y_r;
        sel_s = rd_r[2*COORD_BITS-1 -: COORD_BITS];
      end
      default: begin
        sel_q = q_z_r;
        sel_s = rd_r[COORD_BITS-1:0];
      end
    endcase
  end

  // The difference of two coordinates needs one extra bit; its magnitude fits
  // the same width when read as unsigned.
  assign diff  = $signed({sel_q[COORD_BITS-1], sel_q}) - $signed({sel_s[COORD_BITS-1], sel_s});
  assign mag_c = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

  assign sum_c  = (sq_first_r ? '0 : acc_r) + SUM_W'(sq_r);
  assign decide = (state_r == ST_SCAN) && sq_v_r && sq_last_r;
  assign bump   = CMP_W'(sum_c) < CMP_W'(max_dist_sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_v_r <= 1'b0;
      sq_v_r  <= 1'b0;
    end else begin
      mag_v_r <= issuing;
      sq_v_r  <= mag_v_r && (state_r == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_c;
    mag_first_r <= (ax_r == AX_X);
    mag_last_r  <= (ax_r == AX_Z);
    sq_r        <= mag_r * mag_r;
    sq_first_r  <= mag_first_r;
    sq_last_r   <= mag_last_r;
    if (sq_v_r) begin
      acc_r <= sum_c;
    end
    if (in_acc) begin
      q_x_r <= in_data.pos_x;
      q_y_r <= in_data.pos_y;
      q_z_r <= in_data.pos_z;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    ax_nxt        = ax_r;
    k_nxt         = k_r;
    res_hit_nxt   = res_hit_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_hit_nxt = 1'b0;
          res_idx_nxt = '0;
          j_nxt       = '0;
          ax_nxt      = AX_X;
          k_nxt       = '0;
          state_nxt   = (in_data.mode == MODE_QUERY) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (issuing) begin
          ax_nxt = (ax_r == AX_Z) ? AX_X : ax_r + 2'd1;
          if (ax_r == AX_Z) begin
            j_nxt = j_inc;
          end
        end
        if (n_c == '0) begin
          state_nxt = ST_DONE;
        end else if (decide) begin
          if (bump) begin
            res_hit_nxt = 1'b1;
            res_idx_nxt = k_r[INDEX_W-1:0];
            state_nxt   = ST_DONE;
          end else if (k_inc == n_c) begin
            state_nxt = ST_DONE;
          end else begin
            k_nxt = k_inc;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.hit       = res_hit_r;
          out_data_nxt.hit_index = res_idx_r;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      ax_r        <= AX_X;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      j_r         <= j_nxt;
      ax_r        <= ax_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_hit_r  <= res_hit_nxt;
    res_idx_r  <= res_idx_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: design/pbfhs_checker.sv
// Port-level checker for the point bump first-hit search unit, bound to the
// top level below. Depends on pbfhs_pkg for the payload types.
module pbfhs_checker
  import pbfhs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Reset leaves the block empty and ready for a beat.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // Every accepted beat occupies the block for at least the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a beat");

  // A miss or a load reports slot zero.
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.hit_index == '0)
    else $error("no-hit result with non-zero index");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind point_bump_first_hit_search_unit pbfhs_checker u_pbfhs_checker (.*);

// File: tb/sv/tb_point_bump_first_hit_search_unit.sv
// Self-checking bench for point_bump_first_hit_search_unit: a directed table, then
// random load/query beats with bursty input and patterned output stalls.
// Depends on pbfhs_pkg and the unit itself.
module tb_point_bump_first_hit_search_unit;
  import pbfhs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_ENTRIES   = DEFAULT_MAX_ENTRIES;
  localparam int          CYCLE_LIMIT   = 1_500_000;
  localparam int          HOLDOFF_AT    = 300;
  localparam int          HOLDOFF_LEN   = 600;
  localparam int          DRAIN_CYCLES  = 3 * MAX_ENTRIES + 60;
  localparam logic [63:0] THRESH_TOP    = (64'd1 << THRESH_W) - 64'd1;
  // Squared distance between opposite corners of the coordinate cube.
  localparam logic [63:0] CORNER_DIST_SQ = 64'd3 * 64'hFFFF_FE00_0001;

  localparam logic [COORD_BITS-1:0] C_MIN  = 24'h80_0000;
  localparam logic [COORD_BITS-1:0] C_MAX  = 24'h7F_FFFF;
  localparam logic [COORD_BITS-1:0] C_ZERO = 24'h00_0000;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

  typedef struct {
    row_kind_t   kind;
    logic        reg_sel;
    logic [63:0] reg_val;
    in_item_t    beat;
    bit          typed;
    out_item_t   typed_res;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Bench copy of the table and registers.
  logic signed [COORD_BITS-1:0] atom_x [MAX_ENTRIES];
  logic signed [COORD_BITS-1:0] atom_y [MAX_ENTRIES];
  logic signed [COORD_BITS-1:0] atom_z [MAX_ENTRIES];
  logic [THRESH_W-1:0]          bump_thresh;
  logic [COUNT_W-1:0]           scan_count;

  out_item_t expected_hits[$];
  out_item_t predicted;
  out_item_t got;
  out_item_t want;
  bit        beat_typed;
  out_item_t beat_typed_res;
  int        items_accepted;
  int        results_seen;
  int        fail_count;
  int        burst_left;
  int        cycle_count;

  stall_style_t stall_style;
  int           style_left;
  int           holdoff_left;
  bit           holdoff_done;
  int           stall_tick;

  point_bump_first_hit_search_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Loads update the table; queries return the first slot strictly inside the radius.
  function automatic out_item_t search_first_bump(input in_item_t beat);
    out_item_t res;
    longint    dx;
    longint    dy;
    longint    dz;
    longint    dist_sq;
    int        scan_len;
    res = '0;
    if (beat.mode == MODE_LOAD) begin
      atom_x[beat.entry_index] = beat.pos_x;
      atom_y[beat.entry_index] = beat.pos_y;
      atom_z[beat.entry_index] = beat.pos_z;
    end else begin
      scan_len = (scan_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(scan_count);
      for (int j = 0; j < scan_len; j++) begin
        dx = longint'($signed(beat.pos_x)) - longint'(atom_x[j]);
        dy = longint'($signed(beat.pos_y)) - longint'(atom_y[j]);
        dz = longint'($signed(beat.pos_z)) - longint'(atom_z[j]);
        dist_sq = dx * dx + dy * dy + dz * dz;
        if (dist_sq < longint'(bump_thresh)) begin
          res.hit       = 1'b1;
          res.hit_index = INDEX_W'(j);
          break;
        end
      end
    end
    return res;
  endfunction

  function automatic plan_row_t beat_row(input logic mode, input logic [INDEX_W-1:0] slot,
                                         input logic [COORD_BITS-1:0] x,
                                         input logic [COORD_BITS-1:0] y,
                                         input logic [COORD_BITS-1:0] z,
                                         input bit typed, input logic hit,
                                         input logic [INDEX_W-1:0] hit_index);
    plan_row_t r;
    r.kind                = ROW_BEAT;
    r.reg_sel             = REG_MAX_DIST_SQ;
    r.reg_val             = '0;
    r.beat.mode           = mode;
    r.beat.entry_index    = slot;
    r.beat.pos_x          = x;
    r.beat.pos_y          = y;
    r.beat.pos_z          = z;
    r.typed               = typed;
    r.typed_res.hit       = hit;
    r.typed_res.hit_index = hit_index;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic sel, input logic [63:0] value);
    plan_row_t r;
    r.kind      = ROW_REG;
    r.reg_sel   = sel;
    r.reg_val   = value;
    r.beat      = '0;
    r.typed     = 1'b0;
    r.typed_res = '0;
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] jitter(input logic [COORD_BITS-1:0] base,
                                                   input int spread);
    int off;
    off = int'($urandom_range(0, 2 * spread)) - spread;
    return base + COORD_BITS'(off);
  endfunction

  function automatic logic [COORD_BITS-1:0] corner_coord();
    case ($urandom_range(0, 3))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return C_ZERO;
      default: return '1;
    endcase
  endfunction

  // Random beat: queries are mostly placed on or near a slot inside the scan range.
  function automatic in_item_t make_random_beat(input int n_scan, input int spread);
    in_item_t b;
    int       near_slot;
    int       style;
    b.mode        = ($urandom_range(0, 99) < 30) ? MODE_LOAD : MODE_QUERY;
    b.entry_index = INDEX_W'($urandom);
    near_slot = (b.mode == MODE_QUERY && n_scan > 0) ? $urandom_range(0, n_scan - 1)
                                                     : $urandom_range(0, MAX_ENTRIES - 1);
    style = $urandom_range(0, 99);
    if (style < 25) begin
      b.pos_x = COORD_BITS'($urandom);
      b.pos_y = COORD_BITS'($urandom);
      b.pos_z = COORD_BITS'($urandom);
    end else if (style < 40) begin
      b.pos_x = atom_x[near_slot];
      b.pos_y = atom_y[near_slot];
      b.pos_z = atom_z[near_slot];
    end else if (style < 85) begin
      b.pos_x = jitter(atom_x[near_slot], spread);
      b.pos_y = jitter(atom_y[near_slot], spread);
      b.pos_z = jitter(atom_z[near_slot], spread);
    end else begin
      b.pos_x = corner_coord();
      b.pos_y = corner_coord();
      b.pos_z = corner_coord();
    end
    return b;
  endfunction

  task automatic offer_beat(input in_item_t b, input bit typed, input out_item_t typed_res);
    int gap;
    in_valid       <= 1'b1;
    in_data        <= b;
    beat_typed     <= typed;
    beat_typed_res <= typed_res;
    do @(posedge clk); while (in_stall);
    items_accepted++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drops valid and waits until every accepted beat has produced its result.
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_seen < items_accepted) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(sel) << REG_SEL_BIT;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_MAX_DIST_SQ) begin
      bump_thresh = value[THRESH_W-1:0];
    end else begin
      scan_count = value[COUNT_W-1:0];
    end
  endtask

  // Input side: predict on acceptance. Output side: compare against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted = search_first_bump(in_data);
        expected_hits.push_back(beat_typed ? beat_typed_res : predicted);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        got = out_data;
        if (expected_hits.size() == 0) begin
          $error("result beat with nothing expected: hit=%0d hit_index=%0d",
                 got.hit, got.hit_index);
          fail_count++;
        end else begin
          want = expected_hits.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            fail_count++;
          end
          if (got.hit_index !== want.hit_index) begin
            $error("hit_index: expected %0d, actual %0d", want.hit_index, got.hit_index);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver stall pattern, plus one long hold-off once the run is well under way.
  always @(posedge clk) begin
    stall_tick++;
    style_left--;
    if (style_left <= 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      style_left  = $urandom_range(32, 256);
    end
    if (!holdoff_done && items_accepted >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 25);
        STALL_PERIODIC: out_stall <= (stall_tick % 4 == 0);
        default:        out_stall <= ($urandom_range(0, 99) < 65);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[point_bump_first_hit_search_unit] ERROR");
      $finish;
    end
  end

  initial begin
    plan_row_t   plan[$];
    int          e;
    int          spread;
    int          count_val;
    int          scan_n;
    logic [63:0] thresh_val;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data        <= '0;
    out_stall      <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    beat_typed     <= 1'b0;
    beat_typed_res <= '0;
    bump_thresh    = '0;
    scan_count     = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      atom_x[i] = '0;
      atom_y[i] = '0;
      atom_z[i] = '0;
    end
    items_accepted = 0;
    results_seen   = 0;
    fail_count     = 0;
    burst_left     = 1;
    cycle_count    = 0;
    style_left     = 0;
    holdoff_left   = 0;
    holdoff_done   = 1'b0;
    stall_tick     = 0;

    // Slots 0..3 hold the low corner, high corner, origin and a nearby point.
    plan.push_back(beat_row(MODE_QUERY, 6'h3F, 24'h12_3456, '1, C_MAX, 1, 1'b0, 6'd0));
    plan.push_back(beat_row(MODE_LOAD, 6'd0, C_MIN, C_MIN, C_MIN, 1, 1'b0, 6'd0));
    plan.push_back(beat_row(MODE_LOAD, 6'd1, C_MAX, C_MAX, C_MAX, 1, 1'b0, 6'd0));
    plan.push_back(beat_row(MODE_LOAD, 6'd2, C_ZERO, C_ZERO, C_ZERO, 1, 1'b0, 6'd0));
    plan.push_back(beat_row(MODE_LOAD, 6'd3, COORD_BITS'(-5), COORD_BITS'(12), COORD_BITS'(100),
                            1, 1'b0, 6'd0));
    plan.push_back(beat_row(MODE_LOAD, 6'h3F, 24'h55_5555, 24'h2A_AAAA, '1, 1, 1'b0, 6'd0));
    plan.push_back(reg_row(REG_ATOM_COUNT, 64'd4));
    plan.push_back(reg_row(REG_MAX_DIST_SQ, 64'd25));
    // A squared distance of exactly 25 sits on the boundary and must not count.
    plan.push_back(beat_row(MODE_QUERY, 6'd0, COORD_BITS'(3), COORD_BITS'(4), C_ZERO,
                            1, 1'b0, 6'd0));
    plan.push_back(reg_row(REG_MAX_DIST_SQ, 64'd26));
    plan.push_back(beat_row(MODE_QUERY, 6'd0, COORD_BITS'(3), COORD_BITS'(4), C_ZERO,
                            1, 1'b1, 6'd2));
    plan.push_back(beat_row(MODE_QUERY, 6'h2A, C_MAX, C_MAX, C_MAX, 1, 1'b1, 6'd1));
    plan.push_back(beat_row(MODE_QUERY, 6'h15, C_MIN, C_MIN, C_MIN, 1, 1'b1, 6'd0));
    plan.push_back(beat_row(MODE_QUERY, 6'd9, COORD_BITS'(-5), COORD_BITS'(12), COORD_BITS'(101),
                            0, 1'b0, 6'd0));
    plan.push_back(reg_row(REG_MAX_DIST_SQ, 64'd0));
    plan.push_back(beat_row(MODE_QUERY, 6'd0, C_ZERO, C_ZERO, C_ZERO, 1, 1'b0, 6'd0));
    plan.push_back(reg_row(REG_ATOM_COUNT, 64'd1));
    plan.push_back(reg_row(REG_MAX_DIST_SQ, CORNER_DIST_SQ));
    plan.push_back(beat_row(MODE_QUERY, 6'd0, C_MAX, C_MAX, C_MAX, 1, 1'b0, 6'd0));
    plan.push_back(reg_row(REG_MAX_DIST_SQ, CORNER_DIST_SQ + 64'd1));
    plan.push_back(beat_row(MODE_QUERY, 6'd0, C_MAX, C_MAX, C_MAX, 1, 1'b1, 6'd0));
    plan.push_back(reg_row(REG_MAX_DIST_SQ, THRESH_TOP));
    plan.push_back(beat_row(MODE_QUERY, 6'd7, C_MAX, C_MIN, C_ZERO, 0, 1'b0, 6'd0));
    plan.push_back(beat_row(MODE_LOAD, 6'd0, C_MAX, C_MAX, C_MAX, 1, 1'b0, 6'd0));
    plan.push_back(beat_row(MODE_QUERY, 6'd0, C_MIN, C_MIN, C_MIN, 0, 1'b0, 6'd0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle_idle();
        write_reg(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        offer_beat(plan[i].beat, plan[i].typed, plan[i].typed_res);
      end
    end

    // Fill every slot so that any scan length is legal from here on; odd slots cluster.
    for (int s = 0; s < MAX_ENTRIES; s++) begin
      in_item_t b;
      b.mode        = MODE_LOAD;
      b.entry_index = INDEX_W'(s);
      b.pos_x       = (s % 2) ? jitter(C_ZERO, 4096) : COORD_BITS'($urandom);
      b.pos_y       = (s % 2) ? jitter(C_ZERO, 4096) : COORD_BITS'($urandom);
      b.pos_z       = (s % 2) ? jitter(C_ZERO, 4096) : COORD_BITS'($urandom);
      offer_beat(b, 1'b0, '0);
    end

    for (int p = 0; p < 11; p++) begin
      e      = $urandom_range(0, 22);
      spread = 1 << e;
      case (p)
        1:       thresh_val = 64'd0;
        5:       thresh_val = {$urandom, $urandom} & THRESH_TOP;
        8:       thresh_val = THRESH_TOP;
        default: thresh_val = (64'd1 << (2 * e)) * 64'($urandom_range(1, 3));
      endcase
      case (p)
        0, 8:    count_val = MAX_ENTRIES;
        1:       count_val = 0;
        2:       count_val = 1;
        3:       count_val = (1 << COUNT_W) - 1;
        6:       count_val = 100;
        10:      count_val = 33;
        default: count_val = $urandom_range(2, MAX_ENTRIES);
      endcase
      settle_idle();
      write_reg(REG_ATOM_COUNT, 64'(count_val));
      write_reg(REG_MAX_DIST_SQ, thresh_val);
      scan_n = (count_val > MAX_ENTRIES) ? MAX_ENTRIES : count_val;
      repeat (90) offer_beat(make_random_beat(scan_n, spread), 1'b0, '0);
    end

    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_hits.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_hits.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[point_bump_first_hit_search_unit] OK");
    end else begin
      $display("[point_bump_first_hit_search_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: point_bump_first_hit_search_unit.f
design/pbfhs_pkg.sv
design/point_bump_first_hit_search_unit.sv
design/pbfhs_checker.sv
tb/sv/tb_point_bump_first_hit_search_unit.sv
